FILE: rtl/maf_pkg.sv
// Shared constants and types for the moving-average force scaler.
`default_nettype none
package maf_pkg;

	localparam int WINDOW      = 5;
	localparam int SAMPLE_BITS = 12;
	localparam int AVG_W       = SAMPLE_BITS;
	localparam int TENTHS_W    = 10;

	localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
	localparam int TENTHS_FULL = 1000;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);

	// radix-4 restoring divider for sum / fill
	localparam int RADIX_BITS = 2;
	localparam int DIV_STEPS  = (AVG_W + RADIX_BITS - 1) / RADIX_BITS;
	localparam int QW         = DIV_STEPS * RADIX_BITS;
	localparam int STEP_W     = $clog2(DIV_STEPS + 1);

	// scaled value avg*1000 + FS/2 and its reciprocal product
	localparam int X_W = $clog2(FULL_SCALE * TENTHS_FULL + FULL_SCALE / 2 + 1);
	localparam int P_W = X_W + SAMPLE_BITS + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] fill;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_RECIP,
		ST_FIX
	} back_state_t;

endpackage
`default_nettype wire

FILE: rtl/maf_if.sv
// Sample and result channel interfaces.
`default_nettype none
interface maf_sample_if;
	import maf_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_sample;
	modport source (output valid, output raw_sample, input ready);
	modport sink   (input valid, input raw_sample, output ready);
endinterface

interface maf_result_if;
	import maf_pkg::*;
	logic                valid;
	logic                ready;
	logic [AVG_W-1:0]    average;
	logic [TENTHS_W-1:0] force_tenths;
	modport source (output valid, output average, output force_tenths, input ready);
	modport sink   (input valid, input average, input force_tenths, output ready);
endinterface
`default_nettype wire

FILE: rtl/maf_front.sv
// Front end: sample ring, running sum and fill count; emits one job per beat.
`default_nettype none
module maf_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	maf_sample_if.sink       sample,
	output maf_pkg::job_t    job,
	output logic             job_valid,
	input  wire logic        job_ready
);
	import maf_pkg::*;

	logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
	logic [SLOT_W-1:0]      slot_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       fill_q;

	logic [SAMPLE_BITS-1:0] oldest;
	logic [SUM_W-1:0]       sum_next;
	logic [CNT_W-1:0]       fill_next;
	logic [SLOT_W-1:0]      slot_next;
	logic                   take;

	assign take         = sample.valid & job_ready;
	assign sample.ready = job_ready;

	assign oldest    = ring_q[slot_q];
	assign sum_next  = sum_q - SUM_W'(oldest) + SUM_W'(sample.raw_sample);
	assign fill_next = (fill_q == CNT_W'(WINDOW)) ? fill_q : fill_q + 1'b1;
	assign slot_next = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

	assign job_valid = sample.valid;
	assign job.sum   = sum_next;
	assign job.fill  = fill_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q  <= '0;
			fill_q <= '0;
		end else if (take) begin
			ring_q[slot_q] <= sample.raw_sample;
			slot_q         <= slot_next;
			sum_q          <= sum_next;
			fill_q         <= fill_next;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/maf_queue.sv
// Two-entry job queue between front and back end.
`default_nettype none
module maf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire maf_pkg::job_t push_job,
	input  wire logic          push_valid,
	output logic               push_ready,
	output maf_pkg::job_t      pop_job,
	output logic               pop_valid,
	input  wire logic          pop_ready
);
	import maf_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = mem_q[rd_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/maf_back.sv
// Back end: serial sum/fill divide, tenths scaling, output register.
`default_nettype none
module maf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire maf_pkg::job_t job,
	input  wire logic          job_valid,
	output logic               job_ready,
	maf_result_if.source       result
);
	import maf_pkg::*;

	localparam logic [X_W-1:0] SCALE_X = X_W'(TENTHS_FULL);
	localparam logic [X_W-1:0] HALF_X  = X_W'(FULL_SCALE / 2);
	localparam logic [X_W-1:0] FS_X    = X_W'(FULL_SCALE);

	back_state_t         state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    rem_q;
	logic [QW-1:0]       quo_q;
	logic [CNT_W-1:0]    div_q;
	logic [X_W-1:0]      x_q;
	logic [TENTHS_W-1:0] q0_q;

	logic                out_valid_q;
	logic [AVG_W-1:0]    avg_out_q;
	logic [TENTHS_W-1:0] tenths_out_q;

	logic [CNT_W-1:0]    rem_n;
	logic [QW-1:0]       quo_n;
	logic [P_W-1:0]      prod;
	logic [X_W-1:0]      resid;
	logic [TENTHS_W-1:0] tenths;
	logic                out_free;
	logic                load_out;

	// two quotient bits per cycle
	always_comb begin
		logic [CNT_W:0]   shifted;
		logic [CNT_W+1:0] trial;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < RADIX_BITS; i++) begin
			shifted = {rem_n, quo_n[QW-1]};
			trial   = {1'b0, shifted} - {2'b00, div_q};
			if (!trial[CNT_W+1]) begin
				rem_n = trial[CNT_W-1:0];
				quo_n = {quo_n[QW-2:0], 1'b1};
			end else begin
				rem_n = shifted[CNT_W-1:0];
				quo_n = {quo_n[QW-2:0], 1'b0};
			end
		end
	end

	// x / FS with FS = 2^n - 1: x*(FS+2) >> 2n is low by at most one
	assign prod   = (P_W'(x_q) << SAMPLE_BITS) + P_W'(x_q);
	assign resid  = x_q - ((X_W'(q0_q) << SAMPLE_BITS) - X_W'(q0_q));
	assign tenths = (resid >= FS_X) ? q0_q + 1'b1 : q0_q;

	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_RECIP;
			ST_RECIP: state_d = ST_FIX;
			ST_FIX: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q  <= CNT_W'(job.sum >> QW);
				quo_q  <= job.sum[QW-1:0];
				div_q  <= job.fill;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				step_q <= step_q + 1'b1;
			end
			ST_MUL:   x_q  <= X_W'(quo_q[AVG_W-1:0]) * SCALE_X + HALF_X;
			ST_RECIP: q0_q <= TENTHS_W'(prod >> (2 * SAMPLE_BITS));
			default: ;
		endcase
		if (load_out) begin
			avg_out_q    <= quo_q[AVG_W-1:0];
			tenths_out_q <= tenths;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.average      = avg_out_q;
	assign result.force_tenths = tenths_out_q;

endmodule
`default_nettype wire

FILE: rtl/moving_average_force_scaler.sv
// Top level of the boxcar moving-average force scaler.
//
//   channel  dir  payload                         beat
//   sample   in   raw_sample[11:0]                one converter reading
//   result   out  average[11:0], force_tenths[9:0] one result per sample
//
// A sample beat is taken by the front end (ring, running sum,
// fill count) and queued as a job in a two-entry queue.
// The back end pops a job in its idle state, runs 6 radix-4 divide steps
// for sum / fill, then multiply, reciprocal and correct; it takes no new
// job until the result is loaded into the output register.
// Reset clears the ring, sum, fill count, queue and output valid at once.
// A stalled result holds in the output register while the front end keeps
// taking samples until the queue fills.
`default_nettype none
module moving_average_force_scaler (
	input  wire logic    clk,
	input  wire logic    arst_n,
	maf_sample_if.sink   sample,
	maf_result_if.source result
);
	import maf_pkg::*;

	job_t fq_job;
	logic fq_valid;
	logic fq_ready;
	job_t qb_job;
	logic qb_valid;
	logic qb_ready;

	// front end: updates window state on every accepted beat
	maf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.job       (fq_job),
		.job_valid (fq_valid),
		.job_ready (fq_ready)
	);

	// decouples front from the multi-cycle back end
	maf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (fq_job),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.pop_job    (qb_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready)
	);

	// back end: average and tenths-of-percent scaling
	maf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (qb_job),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.result    (result)
	);

endmodule
`default_nettype wire

FILE: tb/maf_result_checker.sv
// Checker: predicts each result from the sample beats and compares the result beats.
`timescale 1ns / 1ps
module maf_result_checker
	import maf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	maf_sample_if smp,
	maf_result_if res,
	output int    mismatches,
	output int    pending
);

	typedef struct packed {
		logic [AVG_W-1:0]    average;
		logic [TENTHS_W-1:0] force_tenths;
	} force_result_t;

	// own copy of the window state
	logic [SAMPLE_BITS-1:0] ring [WINDOW];
	logic [SLOT_W-1:0]      slot;
	logic [SUM_W-1:0]       window_sum;
	logic [CNT_W-1:0]       fill;

	force_result_t averages_due [$];
	int            miss_count;

	assign mismatches = miss_count;

	// Push one sample through the window and return the result it causes.
	function automatic force_result_t boxcar_step(logic [SAMPLE_BITS-1:0] s);
		force_result_t r;
		int unsigned   avg;
		int unsigned   tenths;
		window_sum = window_sum - SUM_W'(ring[slot]) + SUM_W'(s);
		ring[slot] = s;
		slot       = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
		if (fill < CNT_W'(WINDOW))
			fill = fill + 1'b1;
		avg    = int'(window_sum) / int'(fill);
		tenths = (avg * TENTHS_FULL + FULL_SCALE / 2) / FULL_SCALE;
		r.average      = AVG_W'(avg);
		r.force_tenths = TENTHS_W'(tenths);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		force_result_t got;
		force_result_t want;
		if (!arst_n) begin
			foreach (ring[i])
				ring[i] = '0;
			slot       = '0;
			window_sum = '0;
			fill       = '0;
			miss_count = 0;
			averages_due.delete();
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				got.average      = res.average;
				got.force_tenths = res.force_tenths;
				if (averages_due.size() == 0) begin
					if (miss_count < 10)
						$display("%0t: result beat with nothing due: average %0d force_tenths %0d",
							$realtime, got.average, got.force_tenths);
					miss_count++;
				end else begin
					want = averages_due.pop_front();
					if (got != want) begin
						if (miss_count < 10)
							$display("%0t: mismatch average exp %0d got %0d, force_tenths exp %0d got %0d",
								$realtime, want.average, got.average,
								want.force_tenths, got.force_tenths);
						miss_count++;
					end
				end
			end
			if (smp.valid && smp.ready)
				averages_due.push_back(boxcar_step(smp.raw_sample));
			pending <= averages_due.size();
		end
	end

endmodule

FILE: tb/tb_moving_average_force_scaler.sv
// Testbench top: sample stimulus, result back-pressure, watchdog and verdict.
`timescale 1ns / 1ps
module tb_moving_average_force_scaler;
	import maf_pkg::*;

	localparam int RANDOM_ITEMS = 1050;
	localparam int BLOCK_ITEMS  = 50;
	// generous: longest sender gap + longest result stall + back-end job time
	localparam int IDLE_LIMIT   = 2000;
	// margin after pending reaches zero, to catch any stray result beat
	localparam int DRAIN_CYCLES = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// calm = no gaps on the sample side and ready held high on the result side
	logic calm = 1'b0;
	int   errors;
	int   pending;

	maf_sample_if smp_if ();
	maf_result_if res_if ();

	moving_average_force_scaler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_if),
		.result (res_if)
	);

	maf_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_if),
		.res        (res_if),
		.mismatches (errors),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random sample: uniform, rails, near the rails, and lone bits set or cleared.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int                     r;
		logic [SAMPLE_BITS-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 40)
			v = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
		else if (r < 55)
			v = $urandom_range(0, 1) ? SAMPLE_BITS'(FULL_SCALE) : '0;
		else if (r < 70)
			v = SAMPLE_BITS'($urandom_range(0, 15));
		else if (r < 85)
			v = SAMPLE_BITS'($urandom_range(FULL_SCALE - 15, FULL_SCALE));
		else begin
			v = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
			if ($urandom_range(0, 1))
				v = ~v;
		end
		return v;
	endfunction

	// One sample beat. Valid stays high from one beat to the next unless a gap
	// is drawn, so there is only ever one assignment to valid per edge.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid      <= 1'b1;
		smp_if.raw_sample <= v;
		@(posedge clk);
		while (!smp_if.ready)
			@(posedge clk);
	endtask

	// Result side: ready in runs of random level and length.
	initial begin
		int run_left;
		logic level;
		run_left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm) begin
				res_if.ready <= 1'b1;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					level    = ($urandom_range(0, 99) < 65);
					run_left = pick_gap() + 1;
				end
				res_if.ready <= level;
				run_left--;
			end
		end
	end

	// Watchdog: counts cycles with no beat on either channel.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_moving_average_force_scaler failed");
		$finish;
	end

	// Directed samples. Reset is applied once, so warm-up is only seen here:
	// the first four results divide by 1..4 with the unwritten slots still zero.
	logic [SAMPLE_BITS-1:0] directed_samples [$] = '{
		// warm-up: full scale alone, then a zero, a one and full scale twice
		12'hFFF, 12'h000, 12'h001, 12'hFFF, 12'hFFF,
		// full window of full scale: top of the scale, 1000 tenths
		12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
		// full window of zeros, then small values where rounding sits near a step
		12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
		12'h003, 12'h003, 12'h002,
		// mid scale and alternating bit patterns
		12'h7FF, 12'h800, 12'hAAA, 12'h555
	};

	initial begin
		int sent;
		smp_if.valid      <= 1'b0;
		smp_if.raw_sample <= '0;

		// reset held, then released at an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_samples[i])
			send_sample(directed_samples[i]);

		// random blocks; about one in five runs with no idling at all
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm <= ($urandom_range(0, 4) == 0);
			repeat (BLOCK_ITEMS) begin
				send_sample(pick_sample());
				sent++;
			end
		end

		smp_if.valid <= 1'b0;
		calm         <= 1'b1;

		// pending is registered, so step once before looking at it
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb_moving_average_force_scaler passed");
		else
			$display("tb_moving_average_force_scaler failed");
		$finish;
	end

endmodule
